### rtl/kcalc_pkg.sv
package kcalc_pkg;

	localparam int DEPTH      = 7;
	localparam int MAX_DIGITS = 3;
	localparam int KEY_W      = 8;
	localparam int FILL_W     = 3;
	localparam int OPND_W     = 10;
	localparam int VALUE_W    = 21;
	localparam int ND_W       = 2;
	localparam int DIV_CNT_W  = 4;

	localparam logic [KEY_W-1:0] KEY_EQ     = 8'd61;
	localparam logic [KEY_W-1:0] KEY_ADD    = 8'd43;
	localparam logic [KEY_W-1:0] KEY_SUB    = 8'd45;
	localparam logic [KEY_W-1:0] KEY_MUL    = 8'd42;
	localparam logic [KEY_W-1:0] KEY_DIV    = 8'd47;
	localparam logic [KEY_W-1:0] ASCII_ZERO = 8'd48;
	localparam logic [KEY_W-1:0] ASCII_NINE = 8'd57;

	typedef struct packed {
		logic append;
		logic start;
		logic scan_step;
		logic calc;
		logic div_step;
		logic emit;
	} kcalc_cmd_t;

	typedef struct packed {
		logic scan_end;
		logic eval_bad;
		logic op_div;
		logic div_last;
	} kcalc_stat_t;

endpackage

### rtl/keypad_calculator_engine.sv
// A key other than '=' only updates the buffer.
// An '=' request scans the keys held (0 to 7) one by one, computes the result,
// runs the bit-serial divide for a valid '/', and emits into the result register.
// Throughput: one key per cycle between evaluations; '=' blocks input until emit.
// Reset (arst_n low, asynchronous): buffer and fill count cleared, no result pending.
module keypad_calculator_engine (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [kcalc_pkg::KEY_W-1:0]          key_code,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [kcalc_pkg::VALUE_W-1:0] value,
	output logic                                 bad_entry
);

	// Command and status between the sequencer and the datapath.
	// The sequencer owns the handshakes; the datapath owns the key buffer,
	// the parser, the add/sub/mul unit, the bit-serial divider and the
	// result register.
	kcalc_pkg::kcalc_cmd_t  cmd;
	kcalc_pkg::kcalc_stat_t stat;

	// Sequencer: idle accepts keys; '=' walks scan, compute, divide (valid '/' only), emit.
	// Emit waits while an earlier result is still stalled at the output.
	kcalc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.key_code  (key_code),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Datapath: the parser checks one buffer entry per cycle, building each
	// operand with a times-ten accumulate; division is restoring, one
	// quotient bit per cycle. Errors force the value to zero.
	kcalc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.key_code  (key_code),
		.stat      (stat),
		.value     (value),
		.bad_entry (bad_entry)
	);

endmodule

### rtl/kcalc_dp.sv
module kcalc_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  kcalc_pkg::kcalc_cmd_t               cmd,
	input  logic [kcalc_pkg::KEY_W-1:0]         key_code,
	output kcalc_pkg::kcalc_stat_t              stat,
	output logic signed [kcalc_pkg::VALUE_W-1:0] value,
	output logic                                bad_entry
);

	logic [kcalc_pkg::KEY_W-1:0]    buf_q [kcalc_pkg::DEPTH];
	logic [kcalc_pkg::FILL_W-1:0]   fill_q;
	logic [kcalc_pkg::FILL_W-1:0]   pos_q;
	logic                           phase_q;
	logic                           err_q;
	logic [kcalc_pkg::ND_W-1:0]     nd_q;
	logic [kcalc_pkg::OPND_W-1:0]   lhs_q;
	logic [kcalc_pkg::OPND_W-1:0]   rhs_q;
	logic [kcalc_pkg::KEY_W-1:0]    op_q;
	logic signed [kcalc_pkg::VALUE_W-1:0] res_q;
	logic [kcalc_pkg::OPND_W-1:0]   quo_q;
	logic [kcalc_pkg::OPND_W-1:0]   rem_q;
	logic [kcalc_pkg::DIV_CNT_W-1:0] dcnt_q;
	logic signed [kcalc_pkg::VALUE_W-1:0] value_q;
	logic                           bad_q;

	logic [kcalc_pkg::KEY_W-1:0]    cur_key;
	logic                           cur_digit;
	logic                           cur_op;
	logic [3:0]                     cur_val;
	logic [kcalc_pkg::OPND_W-1:0]   acc_in;
	logic [kcalc_pkg::OPND_W-1:0]   acc_next;
	logic [kcalc_pkg::OPND_W:0]     rem_shift;
	logic                           rem_ge;
	logic                           op_div;
	logic                           eval_bad;

	assign cur_key   = (pos_q < kcalc_pkg::FILL_W'(kcalc_pkg::DEPTH)) ? buf_q[pos_q] : '0;
	assign cur_digit = (cur_key >= kcalc_pkg::ASCII_ZERO) && (cur_key <= kcalc_pkg::ASCII_NINE);
	assign cur_op    = (cur_key == kcalc_pkg::KEY_ADD) || (cur_key == kcalc_pkg::KEY_SUB) ||
	                   (cur_key == kcalc_pkg::KEY_MUL) || (cur_key == kcalc_pkg::KEY_DIV);
	assign cur_val   = 4'(cur_key - kcalc_pkg::ASCII_ZERO);
	assign acc_in    = phase_q ? rhs_q : lhs_q;
	// times ten as two shifts and an add
	assign acc_next  = (acc_in << 3) + (acc_in << 1) + kcalc_pkg::OPND_W'(cur_val);

	assign op_div    = (op_q == kcalc_pkg::KEY_DIV);
	assign eval_bad  = err_q || !phase_q || (nd_q == '0) || (op_div && (rhs_q == '0));

	assign rem_shift = {rem_q[kcalc_pkg::OPND_W-1:0], quo_q[kcalc_pkg::OPND_W-1]};
	assign rem_ge    = (rem_shift >= {1'b0, rhs_q});

	assign stat.scan_end = (pos_q == fill_q);
	assign stat.eval_bad = eval_bad;
	assign stat.op_div   = op_div;
	assign stat.div_last = (dcnt_q == kcalc_pkg::DIV_CNT_W'(kcalc_pkg::OPND_W - 1));

	// key buffer: fill, then slide out the oldest entry once full
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			for (int i = 0; i < kcalc_pkg::DEPTH; i++) buf_q[i] <= '0;
		end else if (cmd.emit) begin
			fill_q <= '0;
			for (int i = 0; i < kcalc_pkg::DEPTH; i++) buf_q[i] <= '0;
		end else if (cmd.append) begin
			if (fill_q < kcalc_pkg::FILL_W'(kcalc_pkg::DEPTH)) begin
				buf_q[fill_q] <= key_code;
				fill_q        <= fill_q + 1'b1;
			end else begin
				for (int i = 0; i < kcalc_pkg::DEPTH - 1; i++) buf_q[i] <= buf_q[i+1];
				buf_q[kcalc_pkg::DEPTH-1] <= key_code;
			end
		end
	end

	// parser: one buffer entry per step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			phase_q <= 1'b0;
			err_q   <= 1'b0;
			nd_q    <= '0;
		end else if (cmd.start) begin
			pos_q   <= '0;
			phase_q <= 1'b0;
			err_q   <= 1'b0;
			nd_q    <= '0;
		end else if (cmd.scan_step) begin
			pos_q <= pos_q + 1'b1;
			if (!err_q) begin
				if (cur_digit) begin
					if (nd_q == kcalc_pkg::ND_W'(kcalc_pkg::MAX_DIGITS)) err_q <= 1'b1;
					else nd_q <= nd_q + 1'b1;
				end else if (!phase_q && cur_op && (nd_q != '0)) begin
					phase_q <= 1'b1;
					nd_q    <= '0;
				end else begin
					err_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			lhs_q <= '0;
			rhs_q <= '0;
		end else if (cmd.scan_step && !err_q && cur_digit) begin
			if (phase_q) rhs_q <= acc_next;
			else lhs_q <= acc_next;
		end
		if (cmd.scan_step && !err_q && !phase_q && !cur_digit) op_q <= cur_key;
	end

	always_ff @(posedge clk) begin
		if (cmd.calc) begin
			unique case (op_q)
				kcalc_pkg::KEY_ADD: res_q <= kcalc_pkg::VALUE_W'(lhs_q) + kcalc_pkg::VALUE_W'(rhs_q);
				kcalc_pkg::KEY_SUB: res_q <= kcalc_pkg::VALUE_W'(lhs_q) - kcalc_pkg::VALUE_W'(rhs_q);
				kcalc_pkg::KEY_MUL: res_q <= kcalc_pkg::VALUE_W'(lhs_q) * kcalc_pkg::VALUE_W'(rhs_q);
				default:            res_q <= '0;
			endcase
			quo_q  <= lhs_q;
			rem_q  <= '0;
			dcnt_q <= '0;
		end else if (cmd.div_step) begin
			// restoring divide, one quotient bit per cycle
			rem_q  <= rem_ge ? kcalc_pkg::OPND_W'(rem_shift - {1'b0, rhs_q})
			                 : rem_shift[kcalc_pkg::OPND_W-1:0];
			quo_q  <= {quo_q[kcalc_pkg::OPND_W-2:0], rem_ge};
			dcnt_q <= dcnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			bad_q <= eval_bad;
			if (eval_bad) value_q <= '0;
			else if (op_div) value_q <= kcalc_pkg::VALUE_W'(quo_q);
			else value_q <= res_q;
		end
	end

	assign value     = value_q;
	assign bad_entry = bad_q;

endmodule

### rtl/kcalc_ctrl.sv
module kcalc_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [kcalc_pkg::KEY_W-1:0] key_code,
	output logic                        out_valid,
	input  logic                        out_stall,
	input  kcalc_pkg::kcalc_stat_t      stat,
	output kcalc_pkg::kcalc_cmd_t       cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SCAN = 3'd1;
	localparam logic [2:0] ST_CALC = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_EMIT = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_nxt;
	logic       out_valid_q;
	logic       in_take;
	logic       out_free;

	assign in_stall = (state_q != ST_IDLE);
	assign in_take  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		cmd           = '0;
		state_nxt     = state_q;
		cmd.append    = in_take && (key_code != kcalc_pkg::KEY_EQ);
		cmd.start     = in_take && (key_code == kcalc_pkg::KEY_EQ);
		unique case (state_q)
			ST_IDLE: if (cmd.start) state_nxt = ST_SCAN;
			ST_SCAN: begin
				if (stat.scan_end) state_nxt = ST_CALC;
				else cmd.scan_step = 1'b1;
			end
			ST_CALC: begin
				cmd.calc  = 1'b1;
				state_nxt = (stat.op_div && !stat.eval_bad) ? ST_DIV : ST_EMIT;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) state_nxt = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_free) begin
					cmd.emit  = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_nxt;
			out_valid_q <= cmd.emit || (out_valid_q && out_stall);
		end
	end

	assign out_valid = out_valid_q;

endmodule

### rtl/kcalc_checker.sv
module kcalc_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 in_valid,
	input logic                                 in_stall,
	input logic [kcalc_pkg::KEY_W-1:0]          key_code,
	input logic                                 out_valid,
	input logic                                 out_stall,
	input logic signed [kcalc_pkg::VALUE_W-1:0] value,
	input logic                                 bad_entry
);

	// an error result always carries a zero value
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bad_entry |-> value == '0)
		else $error("error result with nonzero value");

	// a good result stays within the range reachable from two operands of up to three digits
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !bad_entry |-> (value >= -21'sd999) && (value <= 21'sd998001))
		else $error("result out of range");

	// an accepted '=' holds off the next key while it evaluates
	a_eq_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && key_code == kcalc_pkg::KEY_EQ |=> in_stall)
		else $error("input not stalled during evaluation");

	// a stalled result is neither dropped nor altered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(value) && $stable(bad_entry))
		else $error("stalled result changed");

endmodule

bind keypad_calculator_engine kcalc_checker u_kcalc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.key_code  (key_code),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.value     (value),
	.bad_entry (bad_entry)
);
